// ----- src/tmss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmss_pkg
// Shared types, constants and helper functions for the tethered mass block.
// ----------------------------------------------------------------------------
package tmss_pkg;

    localparam int unsigned QW = 32;     // Q16.16 word width
    localparam int unsigned FRAC = 16;   // fraction bits
    localparam int unsigned CFG_IW = 3;  // config index width

    localparam logic signed [QW-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [QW-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [QW-1:0] S32_MIN = 32'sh8000_0000;

    // Configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CFG_REST_LENGTH    = 3'd0,
        CFG_ELASTIC_LENGTH = 3'd1,
        CFG_SOLID_LINK     = 3'd2,
        CFG_GRAVITY        = 3'd3,
        CFG_RESISTANCE     = 3'd4,
        CFG_MASS           = 3'd5
    } tmss_cfg_idx_t;

    localparam logic [30:0] REST_LENGTH_RST    = 31'd3276800;
    localparam logic [30:0] ELASTIC_LENGTH_RST = 31'd6553600;
    localparam logic [30:0] RESISTANCE_RST     = 31'd32768;
    localparam logic [30:0] MASS_RST           = 31'd327680;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ,
        ST_SQRT,
        ST_UNIT,
        ST_FORCE,
        ST_PULL,
        ST_GRAV,
        ST_DRAG_DIV,
        ST_DRAG,
        ST_POS,
        ST_OUT
    } tmss_state_t;

    typedef struct packed {
        logic signed [QW-1:0] pivot_x;
        logic signed [QW-1:0] pivot_y;
        logic signed [QW-1:0] pivot_z;
    } tmss_pivot_t;

    typedef struct packed {
        logic signed [QW-1:0] mass_x;
        logic signed [QW-1:0] mass_y;
        logic signed [QW-1:0] mass_z;
    } tmss_mass_t;

    // Request to the shared divider
    typedef struct packed {
        logic          start;
        logic [QW-1:0] num_mag;
        logic          neg;
        logic [QW-1:0] den;
    } tmss_div_req_t;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [QW-1:0] sat32(input logic signed [49:0] v);
        logic signed [QW-1:0] r;
        if (v > 50'sd2147483647)
            r = S32_MAX;
        else if (v < -50'sd2147483648)
            r = S32_MIN;
        else
            r = v[QW-1:0];
        return r;
    endfunction

    // Q16.16 product scaling, truncated toward zero
    function automatic logic signed [47:0] qtrunc(input logic signed [63:0] p);
        logic signed [63:0] adj;
        adj = p + (p[63] ? 64'sh0000_0000_0000_FFFF : 64'sh0);
        return adj[63:FRAC];
    endfunction

endpackage

`default_nettype wire

// ----- src/tmss_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmss interfaces
// Valid/ready stream channel and configuration write channel.
// ----------------------------------------------------------------------------
interface tmss_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tmss_cfg_if ();
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

`default_nettype wire

// ----- src/tmss_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmss_mul
// Shared signed 32x32 multiplier with registered product.
// ----------------------------------------------------------------------------
module tmss_mul
    import tmss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic signed [QW-1:0] a,
    input  wire logic signed [QW-1:0] b,
    output logic signed [63:0]        p
);

    logic signed [63:0] p_reg;

    // Register product
    always_ff @(posedge clk)
    begin
        p_reg <= 64'(a) * 64'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

// ----- src/tmss_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmss_div
// Iterative restoring divider: sat32((num << 16) / den), one quotient bit
// per cycle; sign applied on magnitude; zero divisor saturates unless num is zero.
// ----------------------------------------------------------------------------
module tmss_div
    import tmss_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tmss_div_req_t         req,
    output logic                       done,
    output logic signed [QW-1:0]       q
);

    localparam int unsigned NW = QW + FRAC;

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic [NW-1:0]   dvd_reg, dvd_next;
    logic [QW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   quo_reg, quo_next;
    logic [QW-1:0]   den_reg, den_next;
    logic            neg_reg, neg_next;
    logic signed [QW-1:0] q_reg, q_next;

    logic [QW:0]     rem_sh;
    logic            ge;
    logic [NW-1:0]   mag;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        q_reg   <= q_next;
    end

    // One restoring step
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[NW-1]};
        ge     = (rem_sh >= {1'b0, den_reg});
        mag    = {quo_reg[NW-2:0], ge};
    end

    // Advance
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        if (req.start)
        begin
            den_next = req.den;
            neg_next = req.neg;
            dvd_next = {req.num_mag, {FRAC{1'b0}}};
            rem_next = '0;
            quo_next = '0;
            cnt_next = '0;
            if (req.den == '0)
            begin
                done_next = 1'b1;
                if (req.num_mag == '0)
                    q_next = '0;
                else
                    q_next = req.neg ? S32_MIN : S32_MAX;
            end
            else
            begin
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[QW-1:0];
            quo_next = mag;
            dvd_next = {dvd_reg[NW-2:0], 1'b0};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                if (!neg_reg)
                    q_next = (mag > 48'h0000_7FFF_FFFF) ? S32_MAX : mag[QW-1:0];
                else
                    q_next = (mag > 48'h0000_8000_0000) ? S32_MIN : -mag[QW-1:0];
            end
        end
    end

    assign done = done_reg;
    assign q    = q_reg;

endmodule

`default_nettype wire

// ----- src/tmss_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmss_sqrt
// Iterative integer square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module tmss_sqrt
    import tmss_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [63:0]   value,
    output logic               done,
    output logic [QW-1:0]      root
);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [4:0]    cnt_reg, cnt_next;
    logic [63:0]   v_reg, v_next;
    logic [63:0]   res_reg, res_next;
    logic [63:0]   bit_reg, bit_next;
    logic [63:0]   trial;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    // One digit step
    always_comb
    begin
        trial     = res_reg + bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            v_next    = value;
            res_next  = '0;
            bit_next  = 64'h4000_0000_0000_0000;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[QW-1:0];

endmodule

`default_nettype wire

// ----- src/tethered_mass_spring_step_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tethered_mass_spring_step_top
// Point mass on a spring tied to a moving pivot, one tick per request.
//
//   channel    dir   payload                          handshake
//   pivot_in   in    pivot_x, pivot_y, pivot_z        valid / ready
//   mass_out   out   mass_x, mass_y, mass_z           valid / ready
//   cfg        in    index (3b), wdata (32b)          valid / ready (always 1)
//
// Steps of one tick: pivot difference, squares on the shared multiplier,
// square root, unit vector by three divisions on the shared divider, force by
// one division, pull multiplies, gravity, drag factor by one division, drag
// multiplies, position and output, up to five divisions in all. Zero distance
// with a slack link skips four divisions and the pull. Reset clears position,
// velocity, sequencer and output valid, and loads the configuration defaults.
// pivot_in is taken only while the sequencer idles; a stalled mass_out holds
// the finished result and the sequencer waits at the output step.
// ----------------------------------------------------------------------------
module tethered_mass_spring_step_top
    import tmss_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    tmss_stream_if.sink   pivot_in,
    tmss_stream_if.source mass_out,
    tmss_cfg_if.sink      cfg
);

    tmss_state_t state_reg, state_next;

    logic [30:0]          rest_reg, elastic_reg, resist_reg, mass_reg;
    logic                 solid_reg;
    logic signed [QW-1:0] grav_reg;

    logic signed [QW-1:0] pos_reg [3];
    logic signed [QW-1:0] pos_next [3];
    logic signed [QW-1:0] vel_reg [3];
    logic signed [QW-1:0] vel_next [3];
    logic signed [QW-1:0] d_reg [3];
    logic signed [QW-1:0] d_next [3];
    logic signed [QW-1:0] piv_reg [3];
    logic [63:0]          sq_reg, sq_next;
    logic [QW-1:0]        dist_reg, dist_next;
    logic signed [QW-1:0] f_reg, f_next;
    logic signed [QW-1:0] k_reg, k_next;
    logic [1:0]           axis_reg, axis_next;
    logic                 phase_reg, phase_next;
    logic                 out_valid_reg, out_valid_next;
    tmss_mass_t           out_reg;

    logic signed [QW-1:0] mul_a, mul_b;
    logic signed [63:0]   mul_p;
    tmss_div_req_t        div_req;
    logic                 div_done;
    logic signed [QW-1:0] div_q;
    logic                 sqrt_start, sqrt_done;
    logic [QW-1:0]        sqrt_root;

    logic signed [33:0]   stretch;
    logic                 pull_on;
    logic                 in_acc, out_free, last_axis;
    logic signed [QW-1:0] cur_d, cur_v;

    tmss_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

    tmss_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .done(div_done), .q(div_q));

    tmss_sqrt u_sqrt (
        .clk(clk), .rst_n(rst_n), .start(sqrt_start), .value(sq_reg),
        .done(sqrt_done), .root(sqrt_root)
    );

    assign in_acc    = pivot_in.valid && pivot_in.ready;
    assign out_free  = !out_valid_reg || mass_out.ready;
    assign last_axis = (axis_reg == 2'd2);
    assign cur_d     = d_reg[axis_reg];
    assign cur_v     = vel_reg[axis_reg];
    assign stretch   = $signed({2'b00, dist_reg}) - $signed({3'b000, rest_reg});
    assign pull_on   = (stretch > 34'sd0) || solid_reg;

    assign pivot_in.ready = (state_reg == ST_IDLE);
    assign cfg.ready      = 1'b1;
    assign mass_out.valid = out_valid_reg;
    assign mass_out.data  = out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg    <= REST_LENGTH_RST;
            elastic_reg <= ELASTIC_LENGTH_RST;
            solid_reg   <= 1'b0;
            grav_reg    <= '0;
            resist_reg  <= RESISTANCE_RST;
            mass_reg    <= MASS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_REST_LENGTH:    rest_reg    <= cfg.wdata[30:0];
                CFG_ELASTIC_LENGTH: elastic_reg <= cfg.wdata[30:0];
                CFG_SOLID_LINK:     solid_reg   <= cfg.wdata[0];
                CFG_GRAVITY:        grav_reg    <= cfg.wdata;
                CFG_RESISTANCE:     resist_reg  <= cfg.wdata[30:0];
                CFG_MASS:           mass_reg    <= cfg.wdata[30:0];
                default:            ;
            endcase
        end
    end

    // Sequencer and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= pos_next[i];
                vel_reg[i] <= vel_next[i];
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            d_reg[i] <= d_next[i];
        sq_reg   <= sq_next;
        dist_reg <= dist_next;
        f_reg    <= f_next;
        k_reg    <= k_next;
        if (in_acc)
        begin
            piv_reg[0] <= pivot_in.data.pivot_x;
            piv_reg[1] <= pivot_in.data.pivot_y;
            piv_reg[2] <= pivot_in.data.pivot_z;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            out_reg.mass_x <= pos_reg[0];
            out_reg.mass_y <= pos_reg[1];
            out_reg.mass_z <= pos_reg[2];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_acc) state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_SQ;
            ST_SQ:       if (phase_reg && last_axis) state_next = ST_SQRT;
            ST_SQRT:     if (phase_reg && sqrt_done) state_next = ST_UNIT;
            ST_UNIT:
            begin
                if (dist_reg == '0)
                    state_next = ST_FORCE;
                else if (phase_reg && div_done && last_axis)
                    state_next = ST_FORCE;
            end
            ST_FORCE:
            begin
                if (!pull_on)
                    state_next = ST_GRAV;
                else if (phase_reg && div_done)
                    state_next = ST_PULL;
            end
            ST_PULL:     if (phase_reg && last_axis) state_next = ST_GRAV;
            ST_GRAV:     state_next = ST_DRAG_DIV;
            ST_DRAG_DIV: if (phase_reg && div_done) state_next = ST_DRAG;
            ST_DRAG:     if (phase_reg && last_axis) state_next = ST_POS;
            ST_POS:      state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath control and updates
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pos_next[i] = pos_reg[i];
            vel_next[i] = vel_reg[i];
            d_next[i]   = d_reg[i];
        end
        sq_next        = sq_reg;
        dist_next      = dist_reg;
        f_next         = f_reg;
        k_next         = k_reg;
        axis_next      = axis_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        mul_a          = cur_d;
        mul_b          = cur_d;
        sqrt_start     = 1'b0;
        div_req        = '0;

        // Drop the result once taken
        if (out_valid_reg && mass_out.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_DIFF:
            begin
                for (int i = 0; i < 3; i++)
                    d_next[i] = sat32(50'(piv_reg[i]) - 50'(sat32(50'(pos_reg[i])
                                + 50'(vel_reg[i]))));
                sq_next    = '0;
                axis_next  = '0;
                phase_next = 1'b0;
            end
            ST_SQ:
            begin
                // Square one axis, then accumulate
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    sq_next    = sq_reg + mul_p;
                    phase_next = 1'b0;
                    axis_next  = last_axis ? 2'd0 : axis_reg + 2'd1;
                end
            end
            ST_SQRT:
            begin
                if (!phase_reg)
                begin
                    sqrt_start = 1'b1;
                    phase_next = 1'b1;
                end
                else if (sqrt_done)
                begin
                    dist_next  = sqrt_root;
                    phase_next = 1'b0;
                    axis_next  = '0;
                end
            end
            ST_UNIT:
            begin
                // Normalize the pivot vector one axis at a time
                if (dist_reg != '0)
                begin
                    if (!phase_reg)
                    begin
                        div_req.start   = 1'b1;
                        div_req.neg     = cur_d[QW-1];
                        div_req.num_mag = cur_d[QW-1] ? 32'(-cur_d) : cur_d;
                        div_req.den     = dist_reg;
                        phase_next      = 1'b1;
                    end
                    else if (div_done)
                    begin
                        d_next[axis_reg] = div_q;
                        phase_next       = 1'b0;
                        axis_next        = last_axis ? 2'd0 : axis_reg + 2'd1;
                    end
                end
            end
            ST_FORCE:
            begin
                if (pull_on)
                begin
                    if (!phase_reg)
                    begin
                        div_req.start   = 1'b1;
                        div_req.neg     = stretch[33];
                        div_req.num_mag = stretch[33] ? 32'(-stretch) : stretch[31:0];
                        div_req.den     = {1'b0, elastic_reg};
                        phase_next      = 1'b1;
                    end
                    else if (div_done)
                    begin
                        f_next     = div_q;
                        phase_next = 1'b0;
                        axis_next  = '0;
                    end
                end
            end
            ST_PULL:
            begin
                mul_b = f_reg;
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    vel_next[axis_reg] = sat32(50'(cur_v) + 50'(qtrunc(mul_p)));
                    phase_next         = 1'b0;
                    axis_next          = last_axis ? 2'd0 : axis_reg + 2'd1;
                end
            end
            ST_GRAV:
            begin
                vel_next[1] = sat32(50'(vel_reg[1]) - 50'(grav_reg));
                phase_next  = 1'b0;
            end
            ST_DRAG_DIV:
            begin
                if (!phase_reg)
                begin
                    div_req.start   = 1'b1;
                    div_req.neg     = 1'b0;
                    div_req.num_mag = {1'b0, resist_reg};
                    div_req.den     = {1'b0, mass_reg};
                    phase_next      = 1'b1;
                end
                else if (div_done)
                begin
                    k_next     = sat32(50'(Q_ONE) - 50'(div_q));
                    phase_next = 1'b0;
                    axis_next  = '0;
                end
            end
            ST_DRAG:
            begin
                // Scale velocity by the drag factor
                mul_a = cur_v;
                mul_b = k_reg;
                if (!phase_reg)
                begin
                    phase_next = 1'b1;
                end
                else
                begin
                    vel_next[axis_reg] = sat32(50'(qtrunc(mul_p)));
                    phase_next         = 1'b0;
                    axis_next          = last_axis ? 2'd0 : axis_reg + 2'd1;
                end
            end
            ST_POS:
            begin
                for (int i = 0; i < 3; i++)
                    pos_next[i] = sat32(50'(pos_reg[i]) + 50'(vel_reg[i]));
            end
            ST_OUT:
            begin
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ----- tb/tmss_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmss_checker
// Watches the pivot, mass and configuration channels of the tethered mass
// block, predicts each new mass position in fixed point and compares every
// result field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tmss_checker
    import tmss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pivot_valid,
    input  logic        pivot_ready,
    input  tmss_pivot_t pivot_data,
    input  logic        mass_valid,
    input  logic        mass_ready,
    input  tmss_mass_t  mass_data,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    output int          errors,
    output int          pending,
    output int          results
);

    localparam longint MAXV = 64'sd2147483647;
    localparam longint MINV = -64'sd2147483648;

    // predictor copy of registers and mass state
    longint     rest_len, elastic_len, solid, gravity, drag_num, mass_val;
    longint     pos [3];
    longint     vel [3];
    tmss_mass_t positions_due [$];

    function automatic longint clip(input longint v);
        if (v > MAXV)
            return MAXV;
        if (v < MINV)
            return MINV;
        return v;
    endfunction

    function automatic longint fx_mul(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p < 0)
            return -((-p) >>> 16);
        return p >>> 16;
    endfunction

    function automatic longint fx_div(input longint num, input longint den);
        if (den == 0)
        begin
            if (num > 0)
                return MAXV;
            if (num < 0)
                return MINV;
            return 0;
        end
        return clip((num * 65536) / den);
    endfunction

    function automatic bit [63:0] root_floor(input bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // advance the mass by one tick and return its new position
    function automatic tmss_mass_t advance_mass(input tmss_pivot_t pv);
        longint     piv [3];
        longint     d [3];
        longint     u [3];
        longint     trial, stretch, f, k;
        bit [63:0]  sq, span;
        tmss_mass_t r;
        piv[0] = pv.pivot_x;
        piv[1] = pv.pivot_y;
        piv[2] = pv.pivot_z;
        sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            trial = clip(pos[i] + vel[i]);
            d[i] = clip(piv[i] - trial);
            sq = sq + 64'(d[i] * d[i]);
        end
        span = root_floor(sq);
        stretch = longint'(span) - rest_len;
        for (int i = 0; i < 3; i++)
            u[i] = (span != 0) ? fx_div(d[i], longint'(span)) : d[i];
        if (stretch > 0 || solid != 0)
        begin
            f = fx_div(stretch, elastic_len);
            for (int i = 0; i < 3; i++)
                vel[i] = clip(vel[i] + fx_mul(u[i], f));
        end
        vel[1] = clip(vel[1] - gravity);
        k = clip(64'sd65536 - fx_div(drag_num, mass_val));
        for (int i = 0; i < 3; i++)
        begin
            vel[i] = clip(fx_mul(vel[i], k));
            pos[i] = clip(pos[i] + vel[i]);
        end
        r.mass_x = pos[0][31:0];
        r.mass_y = pos[1][31:0];
        r.mass_z = pos[2][31:0];
        return r;
    endfunction

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        errors = errors + 1;
        if (errors <= 10)
            $display("%0t tmss_checker: %s mismatch, expected %h got %h", $time, field, want, got);
    endtask

    // track registers, predict on each accepted pivot, compare on each result
    always @(posedge clk or negedge rst_n)
    begin
        tmss_mass_t want;
        if (!rst_n)
        begin
            rest_len    = REST_LENGTH_RST;
            elastic_len = ELASTIC_LENGTH_RST;
            solid       = 0;
            gravity     = 0;
            drag_num    = RESISTANCE_RST;
            mass_val    = MASS_RST;
            for (int i = 0; i < 3; i++)
            begin
                pos[i] = 0;
                vel[i] = 0;
            end
            positions_due.delete();
            errors  = 0;
            results = 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_REST_LENGTH:    rest_len    = cfg_wdata[30:0];
                    CFG_ELASTIC_LENGTH: elastic_len = cfg_wdata[30:0];
                    CFG_SOLID_LINK:     solid       = cfg_wdata[0];
                    CFG_GRAVITY:        gravity     = $signed(cfg_wdata);
                    CFG_RESISTANCE:     drag_num    = cfg_wdata[30:0];
                    CFG_MASS:           mass_val    = cfg_wdata[30:0];
                    default: ;
                endcase
            end
            if (pivot_valid && pivot_ready)
                positions_due.push_back(advance_mass(pivot_data));
            if (mass_valid && mass_ready)
            begin
                results = results + 1;
                if (positions_due.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("%0t tmss_checker: result %h with nothing expected",
                                 $time, mass_data);
                end
                else
                begin
                    want = positions_due.pop_front();
                    if (want.mass_x !== mass_data.mass_x)
                        report("mass_x", want.mass_x, mass_data.mass_x);
                    if (want.mass_y !== mass_data.mass_y)
                        report("mass_y", want.mass_y, mass_data.mass_y);
                    if (want.mass_z !== mass_data.mass_z)
                        report("mass_z", want.mass_z, mass_data.mass_z);
                end
            end
            pending <= positions_due.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives pivot ticks and register settings into the tethered mass block
// under several idling patterns, with a long output hold-off and a full
// drain pause, and reports the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module tb_top;
    import tmss_pkg::*;

    localparam logic [2:0] CFG_UNUSED = 3'd6;
    localparam int         LIMIT      = 4000000;
    localparam int         TAIL       = 300;

    logic clk;
    logic rst_n;
    int   errors, pending, results;
    int   send_idle_pct, recv_stall_pct, hold_off;
    int   ticks_sent, phases_run;
    int   cycles;

    tmss_stream_if #(.T(tmss_pivot_t)) pivot_in ();
    tmss_stream_if #(.T(tmss_mass_t))  mass_out ();
    tmss_cfg_if                        cfg ();

    tethered_mass_spring_step_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .pivot_in (pivot_in),
        .mass_out (mass_out),
        .cfg      (cfg)
    );

    tmss_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .pivot_valid (pivot_in.valid),
        .pivot_ready (pivot_in.ready),
        .pivot_data  (pivot_in.data),
        .mass_valid  (mass_out.valid),
        .mass_ready  (mass_out.ready),
        .mass_data   (mass_out.data),
        .cfg_valid   (cfg.valid),
        .cfg_ready   (cfg.ready),
        .cfg_index   (cfg.index),
        .cfg_wdata   (cfg.wdata),
        .errors      (errors),
        .pending     (pending),
        .results     (results)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // drive the result ready, with random stalls and counted hold-offs
    initial
    begin
        mass_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                mass_out.ready <= 1'b0;
                hold_off = hold_off - 1;
            end
            else
                mass_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // end the run if it hangs
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles = cycles + 1;
            if (cycles > LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3, 4, 5, 6: return $urandom_range(2 * (200 << 16)) - (200 << 16);
            default: return $urandom;
        endcase
    endfunction

    // offer one pivot request, keeping valid high across back-to-back requests
    task automatic send_pivot(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        if ($urandom_range(99) < send_idle_pct)
        begin
            pivot_in.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        pivot_in.valid <= 1'b1;
        pivot_in.data  <= '{x, y, z};
        @(posedge clk);
        while (!pivot_in.ready)
            @(posedge clk);
        ticks_sent = ticks_sent + 1;
    endtask

    // hold until every result is back, then let the block settle
    task automatic drain();
        pivot_in.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
    endtask

    // write the whole register set plus an ignored index, valid held high
    task automatic load_regs(input logic [31:0] v [6]);
        for (int i = 0; i < 7; i++)
        begin
            cfg.valid <= 1'b1;
            cfg.index <= (i == 6) ? CFG_UNUSED : 3'(i);
            cfg.wdata <= (i == 6) ? $urandom : v[i];
            @(posedge clk);
            while (!cfg.ready)
                @(posedge clk);
        end
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_regs();
        logic [31:0] v [6];
        v[CFG_REST_LENGTH]    = ($urandom_range(3) == 0) ? $urandom : $urandom_range(200 << 16);
        v[CFG_ELASTIC_LENGTH] = ($urandom_range(3) == 0) ? $urandom
                                                          : $urandom_range(1, 400 << 16);
        v[CFG_SOLID_LINK]     = $urandom;
        v[CFG_GRAVITY]        = ($urandom_range(3) == 0) ? $urandom
                                                          : $urandom_range(1 << 16) - (1 << 15);
        v[CFG_RESISTANCE]     = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 16);
        v[CFG_MASS]           = ($urandom_range(3) == 0) ? $urandom
                                                          : $urandom_range(1, 20 << 16);
        load_regs(v);
    endtask

    task automatic run_phase(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++)
        begin
            // mostly pivots near the origin so the spring stays in play
            if ($urandom_range(4) != 0)
                send_pivot($urandom_range(2 * (120 << 16)) - (120 << 16),
                           $urandom_range(2 * (120 << 16)) - (120 << 16),
                           $urandom_range(2 * (120 << 16)) - (120 << 16));
            else
                send_pivot(pick_word(), pick_word(), pick_word());
        end
        drain();
        phases_run = phases_run + 1;
    endtask

    initial
    begin
        logic [31:0] v [6];
        pivot_in.valid = 1'b0;
        pivot_in.data  = '0;
        cfg.valid      = 1'b0;
        cfg.index      = CFG_REST_LENGTH;
        cfg.wdata      = '0;
        hold_off       = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        ticks_sent     = 0;
        phases_run     = 0;
        rst_n          = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero distance at rest, then field extremes on reset values
        send_pivot(32'h0, 32'h0, 32'h0);
        send_pivot(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pivot(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_pivot(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
        send_pivot(32'h0000_0001, 32'hFFFF_FFFF, 32'h0010_0000);
        drain();

        // directed: solid rod, zero elasticity, zero mass, extreme gravity
        v[CFG_REST_LENGTH]    = 32'h0;
        v[CFG_ELASTIC_LENGTH] = 32'h0;
        v[CFG_SOLID_LINK]     = 32'h1;
        v[CFG_GRAVITY]        = 32'h8000_0000;
        v[CFG_RESISTANCE]     = 32'h7FFF_FFFF;
        v[CFG_MASS]           = 32'h0;
        load_regs(v);
        send_pivot(32'h0, 32'h0, 32'h0);
        send_pivot(32'h0010_0000, 32'hFFF0_0000, 32'h0);
        send_pivot(32'h7FFF_FFFF, 32'h0, 32'h8000_0000);
        drain();

        // directed: other corner of the register space
        v[CFG_REST_LENGTH]    = 32'hFFFF_FFFF;
        v[CFG_ELASTIC_LENGTH] = 32'h7FFF_FFFF;
        v[CFG_SOLID_LINK]     = 32'h0;
        v[CFG_GRAVITY]        = 32'h7FFF_FFFF;
        v[CFG_RESISTANCE]     = 32'h0;
        v[CFG_MASS]           = 32'h7FFF_FFFF;
        load_regs(v);
        for (int i = 0; i < 6; i++)
            send_pivot(pick_word(), pick_word(), pick_word());
        drain();

        // slack link with mild drag and a zero stretch divisor
        v[CFG_REST_LENGTH]    = 32'd3276800;
        v[CFG_ELASTIC_LENGTH] = 32'h0;
        v[CFG_SOLID_LINK]     = 32'h0;
        v[CFG_GRAVITY]        = 32'h0000_4000;
        v[CFG_RESISTANCE]     = 32'h0000_1000;
        v[CFG_MASS]           = 32'h0005_0000;
        load_regs(v);
        send_pivot(32'h0064_0000, 32'h0, 32'h0);
        send_pivot(32'h0001_0000, 32'h0, 32'h0);
        send_pivot(32'hFF9C_0000, 32'h0032_0000, 32'h0);
        drain();

        // random phases across the idling patterns
        random_regs();
        run_phase(160, 0, 0);
        random_regs();
        run_phase(160, 68, 0);
        random_regs();
        run_phase(160, 0, 68);
        random_regs();
        run_phase(160, 12, 12);

        // long output hold-off while pivots keep coming
        random_regs();
        hold_off = 3000;
        run_phase(60, 0, 0);

        // mid-stream pause until every result is back
        random_regs();
        send_idle_pct  = 0;
        recv_stall_pct = 30;
        for (int i = 0; i < 20; i++)
            send_pivot(pick_word(), pick_word(), pick_word());
        drain();
        run_phase(100, 0, 30);

        for (int p = 0; p < 4; p++)
        begin
            random_regs();
            run_phase(120, (p % 2) ? 68 : 12, (p < 2) ? 68 : 12);
        end

        $display("tb_top: %0d pivot ticks in %0d random phases, %0d results checked",
                 ticks_sent, phases_run, results);
        $display("tb_top: covered solid and slack links, zero divisors, stalls and hold-off");
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
